// ===== rtl/core/ndh_pkg.sv =====
// ----------------------------------------------------------------------------
// ndh_pkg
// Shared constants, codes and types of the neighbor deduplication block.
// ----------------------------------------------------------------------------
package ndh_pkg;

  localparam int unsigned DEF_NODE_BITS  = 20;
  localparam int unsigned DEF_HASH_BITS  = 12;
  localparam int unsigned DEF_EDGE_BITS  = 32;
  localparam int unsigned DEF_HASH_PRIME = 37;

  localparam int unsigned MIN_TABLE_BITS = 5;
  localparam int unsigned TBITS_W        = 4;
  localparam int unsigned SHIFT_W        = 5;
  localparam int unsigned OFFSET_BITS    = 20;
  localparam int unsigned PEAK_BITS      = 13;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 20;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [TBITS_W-1:0]   TABLE_BITS_RESET = 4'd12;
  localparam logic [PEAK_BITS-1:0] PEAK_MAX         = 13'h1FFF;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_CAND   = 2'd1,
    OP_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TABLE_BITS  = 2'd0,
    REG_NODE_OFFSET = 2'd1,
    REG_BASE_VALUE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic value;
  } base_load_t;

endpackage

// ===== rtl/core/ndh_ram.sv =====
// ----------------------------------------------------------------------------
// ndh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ndh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ndh_fifo.sv =====
// ----------------------------------------------------------------------------
// ndh_fifo
// Short queue that decouples the classifying front from the probing back.
// ----------------------------------------------------------------------------
module ndh_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/ndh_front.sv =====
// ----------------------------------------------------------------------------
// ndh_front
// Configuration registers, item classification, hashing and index translation.
// ----------------------------------------------------------------------------
module ndh_front #(
  parameter int unsigned NODE_BITS  = ndh_pkg::DEF_NODE_BITS,
  parameter int unsigned HASH_BITS  = ndh_pkg::DEF_HASH_BITS,
  parameter int unsigned HASH_PRIME = ndh_pkg::DEF_HASH_PRIME
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ndh_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [ndh_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         command_i,
  input  logic [NODE_BITS-1:0]               node_i,
  input  logic                               full_i,
  input  logic                               busy_i,
  output logic                               push_o,
  output logic [1:0]                         op_o,
  output logic [NODE_BITS-1:0]               node_o,
  output logic [HASH_BITS-1:0]               hash_o,
  output logic signed [NODE_BITS:0]          xlat_o,
  output logic [HASH_BITS-1:0]               mask_o,
  output ndh_pkg::base_load_t                base_load_o
);

  import ndh_pkg::*;

  localparam int unsigned TW = ((NODE_BITS > OFFSET_BITS) ? NODE_BITS : OFFSET_BITS) + 2;
  localparam logic [NODE_BITS-1:0] NODE_MASK = '1;
  localparam logic [HASH_BITS-1:0] PRIME_LO  = HASH_BITS'(HASH_PRIME);

  logic [TBITS_W-1:0]     tbits_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic                   base_q;
  logic [SHIFT_W-1:0]     tb_ext, eff_bits;
  logic [HASH_BITS-1:0]   prod;
  logic signed [TW-1:0]   diff, clip;
  logic                   keep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbits_q  <= TABLE_BITS_RESET;
      offset_q <= '0;
      base_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TABLE_BITS:  tbits_q  <= cfg_data_i[TBITS_W-1:0];
        REG_NODE_OFFSET: offset_q <= cfg_data_i[OFFSET_BITS-1:0];
        REG_BASE_VALUE:  base_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign base_load_o.load  = cfg_valid_i && (cfg_index_i == REG_BASE_VALUE);
  assign base_load_o.value = cfg_data_i[0];

  // clamp the table size to the range the table supports
  always_comb begin
    tb_ext = SHIFT_W'(tbits_q);
    if (tb_ext < SHIFT_W'(MIN_TABLE_BITS)) begin
      eff_bits = SHIFT_W'(MIN_TABLE_BITS);
    end else if (tb_ext > SHIFT_W'(HASH_BITS)) begin
      eff_bits = SHIFT_W'(HASH_BITS);
    end else begin
      eff_bits = tb_ext;
    end
  end

  assign mask_o = ~({HASH_BITS{1'b1}} << eff_bits);
  assign prod   = HASH_BITS'(node_i) * PRIME_LO;
  assign hash_o = prod & mask_o;

  // translate and saturate the neighbor index
  always_comb begin
    diff = $signed(TW'(node_i)) - $signed(TW'(offset_q)) + $signed(TW'(base_q));
    clip = (diff > $signed(TW'(NODE_MASK))) ? $signed(TW'(NODE_MASK)) : diff;
  end

  assign xlat_o = clip[NODE_BITS:0];

  // drop unknown commands and begins with no vertex
  always_comb begin
    case (command_i)
      OP_BEGIN:  keep = (node_i != NODE_MASK);
      OP_CAND:   keep = 1'b1;
      OP_FINISH: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i && !busy_i;
  assign push_o     = in_valid_i && in_ready_o && keep;
  assign op_o       = command_i;
  assign node_o     = node_i;

endmodule

// ===== rtl/core/ndh_back.sv =====
// ----------------------------------------------------------------------------
// ndh_back
// Table clearing, linear probing, counters and the result register.
// ----------------------------------------------------------------------------
module ndh_back #(
  parameter int unsigned NODE_BITS = ndh_pkg::DEF_NODE_BITS,
  parameter int unsigned HASH_BITS = ndh_pkg::DEF_HASH_BITS,
  parameter int unsigned EDGE_BITS = ndh_pkg::DEF_EDGE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [HASH_BITS-1:0]           mask_i,
  input  ndh_pkg::base_load_t            base_load_i,
  input  logic                           head_valid_i,
  input  logic [1:0]                     head_op_i,
  input  logic [NODE_BITS-1:0]           head_node_i,
  input  logic [HASH_BITS-1:0]           head_hash_i,
  input  logic signed [NODE_BITS:0]      head_xlat_i,
  output logic                           pop_o,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic signed [NODE_BITS:0]      neighbor_out_o,
  output logic [EDGE_BITS-1:0]           edge_count_o,
  output logic [ndh_pkg::PEAK_BITS-1:0]  max_degree_o,
  output logic                           overflow_o
);

  import ndh_pkg::*;

  localparam int unsigned DEPTH = 1 << HASH_BITS;
  localparam int unsigned EW    = 2 * NODE_BITS;
  localparam int unsigned DW    = (EDGE_BITS > PEAK_BITS) ? EDGE_BITS : PEAK_BITS;
  localparam logic [NODE_BITS-1:0] NODE_MASK = '1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [HASH_BITS-1:0]    clr_q, clr_d;
  logic [HASH_BITS-1:0]    probe_q, probe_d, probe_next;
  logic [HASH_BITS-1:0]    lap_q, lap_d;
  logic [NODE_BITS-1:0]    node_q, node_d;
  logic signed [NODE_BITS:0] xlat_q, xlat_d;
  logic [NODE_BITS-1:0]    cur_q, cur_d;
  logic [EDGE_BITS-1:0]    edge_q, edge_d, start_q, start_d, edge_inc, deg;
  logic [PEAK_BITS-1:0]    peak_q, peak_d, deg_sat;
  logic [DW-1:0]           deg_ext;
  logic                    ovf_q, ovf_d;

  logic                    out_valid_q;
  logic [1:0]              res_kind_q, res_kind_d;
  logic signed [NODE_BITS:0] res_nb_q, res_nb_d;
  logic [EDGE_BITS-1:0]    res_cnt_q, res_cnt_d;
  logic [PEAK_BITS-1:0]    res_peak_q;
  logic                    res_ovf_q;
  logic                    out_load, out_free;

  logic                    ram_we, ram_re;
  logic [HASH_BITS-1:0]    ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;
  logic [NODE_BITS-1:0]    rd_owner, rd_nbr;

  ndh_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_owner   = ram_rdata[EW-1:NODE_BITS];
  assign rd_nbr     = ram_rdata[NODE_BITS-1:0];
  assign out_free   = !out_valid_q || out_ready_i;
  assign probe_next = (probe_q + HASH_BITS'(1)) & mask_i;
  assign edge_inc   = edge_q + EDGE_BITS'(1);
  assign deg        = edge_inc - start_q;
  assign deg_ext    = DW'(deg);
  assign deg_sat    = (deg_ext > DW'(PEAK_MAX)) ? PEAK_MAX : deg_ext[PEAK_BITS-1:0];
  assign busy_o     = (state_q == ST_CLEAR);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    probe_d    = probe_q;
    lap_d      = lap_q;
    node_d     = node_q;
    xlat_d     = xlat_q;
    cur_d      = cur_q;
    edge_d     = edge_q;
    start_d    = start_q;
    peak_d     = peak_q;
    ovf_d      = ovf_q;
    ram_we     = 1'b0;
    ram_waddr  = probe_q;
    ram_wdata  = '1;
    ram_re     = 1'b0;
    ram_raddr  = probe_q;
    pop_o      = 1'b0;
    out_load   = 1'b0;
    res_kind_d = KIND_START;
    res_nb_d   = '0;
    res_cnt_d  = edge_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + HASH_BITS'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_op_i)
            OP_BEGIN: begin
              if (out_free) begin
                ram_we     = 1'b1;
                ram_waddr  = head_hash_i;
                ram_wdata  = {head_node_i, head_node_i};
                cur_d      = head_node_i;
                start_d    = edge_q;
                pop_o      = 1'b1;
                out_load   = 1'b1;
                res_kind_d = KIND_START;
              end
            end
            OP_CAND: begin
              pop_o = 1'b1;
              if (cur_q != NODE_MASK) begin
                ram_re    = 1'b1;
                ram_raddr = head_hash_i;
                probe_d   = head_hash_i;
                lap_d     = '0;
                node_d    = head_node_i;
                xlat_d    = head_xlat_i;
                state_d   = ST_CHECK;
              end
            end
            OP_FINISH: begin
              if (out_free) begin
                pop_o      = 1'b1;
                out_load   = 1'b1;
                res_kind_d = KIND_SUMMARY;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_CHECK: begin
        if (rd_owner != cur_q) begin
          if (out_free) begin
            ram_we     = 1'b1;
            ram_wdata  = {cur_q, node_q};
            edge_d     = edge_inc;
            peak_d     = (deg_sat > peak_q) ? deg_sat : peak_q;
            out_load   = 1'b1;
            res_kind_d = KIND_EDGE;
            res_nb_d   = xlat_q;
            state_d    = ST_IDLE;
          end
        end else if (rd_nbr == node_q) begin
          state_d = ST_IDLE;
        end else if (lap_q == mask_i) begin
          ovf_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          probe_d   = probe_next;
          lap_d     = lap_q + HASH_BITS'(1);
          ram_re    = 1'b1;
          ram_raddr = probe_next;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (base_load_i.load) begin
      edge_d  = EDGE_BITS'(base_load_i.value);
      start_d = EDGE_BITS'(base_load_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= NODE_MASK;
      edge_q      <= '0;
      start_q     <= '0;
      peak_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cur_q   <= cur_d;
      edge_q  <= edge_d;
      start_q <= start_d;
      peak_q  <= peak_d;
      ovf_q   <= ovf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    lap_q   <= lap_d;
    node_q  <= node_d;
    xlat_q  <= xlat_d;
    if (out_load) begin
      res_kind_q <= res_kind_d;
      res_nb_q   <= res_nb_d;
      res_cnt_q  <= res_cnt_d;
      res_peak_q <= peak_d;
      res_ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_kind_q;
  assign neighbor_out_o = res_nb_q;
  assign edge_count_o   = res_cnt_q;
  assign max_degree_o   = res_peak_q;
  assign overflow_o     = res_ovf_q;

endmodule

// ===== rtl/core/neighbor_dedup_hash.sv =====
// ----------------------------------------------------------------------------
// neighbor_dedup_hash
// Removes duplicate neighbors of one vertex at a time with a stamped
// open-addressing hash table probed linearly. Begin and finish items wait
// for a free result register; a candidate reads its hash slot, then the next
// slots one at a time (the table RAM has a single read port) until a free or
// foreign slot takes it, its own entry marks a duplicate, or a full lap sets
// the overflow flag; the next item is taken only once it is settled. A
// two-entry queue keeps taking items until full while the engine probes or a
// result waits. After reset the table is swept to no owner, during which no
// item is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module neighbor_dedup_hash #(
  parameter int unsigned NODE_BITS  = ndh_pkg::DEF_NODE_BITS,
  parameter int unsigned HASH_BITS  = ndh_pkg::DEF_HASH_BITS,
  parameter int unsigned EDGE_BITS  = ndh_pkg::DEF_EDGE_BITS,
  parameter int unsigned HASH_PRIME = ndh_pkg::DEF_HASH_PRIME
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ndh_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [ndh_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [NODE_BITS-1:0]              node_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        kind_o,
  output logic signed [NODE_BITS:0]         neighbor_out_o,
  output logic [EDGE_BITS-1:0]              edge_count_o,
  output logic [ndh_pkg::PEAK_BITS-1:0]     max_degree_o,
  output logic                              overflow_o
);

  import ndh_pkg::*;

  localparam int unsigned QW = 2 + NODE_BITS + HASH_BITS + NODE_BITS + 1;

  logic                      push, pop, full, empty;
  logic [1:0]                f_op, h_op;
  logic [NODE_BITS-1:0]      f_node, h_node;
  logic [HASH_BITS-1:0]      f_hash, h_hash, mask;
  logic signed [NODE_BITS:0] f_xlat, h_xlat;
  logic [QW-1:0]             q_wdata, q_rdata;
  logic                      busy;
  base_load_t                base_load;

  ndh_front #(
    .NODE_BITS  (NODE_BITS),
    .HASH_BITS  (HASH_BITS),
    .HASH_PRIME (HASH_PRIME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .node_i      (node_i),
    .full_i      (full),
    .busy_i      (busy),
    .push_o      (push),
    .op_o        (f_op),
    .node_o      (f_node),
    .hash_o      (f_hash),
    .xlat_o      (f_xlat),
    .mask_o      (mask),
    .base_load_o (base_load)
  );

  assign q_wdata = {f_op, f_node, f_hash, f_xlat};

  ndh_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {h_op, h_node, h_hash, h_xlat} = q_rdata;

  ndh_back #(
    .NODE_BITS (NODE_BITS),
    .HASH_BITS (HASH_BITS),
    .EDGE_BITS (EDGE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mask_i         (mask),
    .base_load_i    (base_load),
    .head_valid_i   (!empty),
    .head_op_i      (h_op),
    .head_node_i    (h_node),
    .head_hash_i    (h_hash),
    .head_xlat_i    (h_xlat),
    .pop_o          (pop),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .neighbor_out_o (neighbor_out_o),
    .edge_count_o   (edge_count_o),
    .max_degree_o   (max_degree_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== rtl/core/ndh_checker.sv =====
// ----------------------------------------------------------------------------
// ndh_checker
// Port-level checks on the result channel of the deduplication block.
// ----------------------------------------------------------------------------
module ndh_checker #(
  parameter int unsigned NODE_BITS = ndh_pkg::DEF_NODE_BITS,
  parameter int unsigned EDGE_BITS = ndh_pkg::DEF_EDGE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [1:0]                    kind_o,
  input  logic signed [NODE_BITS:0]     neighbor_out_o,
  input  logic [EDGE_BITS-1:0]          edge_count_o,
  input  logic [ndh_pkg::PEAK_BITS-1:0] max_degree_o,
  input  logic                          overflow_o
);

  import ndh_pkg::*;

  logic                 ovf_seen_q;
  logic [PEAK_BITS-1:0] last_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_seen_q  <= 1'b0;
      last_peak_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      ovf_seen_q  <= ovf_seen_q || overflow_o;
      last_peak_q <= max_degree_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(neighbor_out_o) && $stable(edge_count_o)
      && $stable(max_degree_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_EDGE) |-> (neighbor_out_o == '0))
    else $error("nonzero neighbor index outside an edge result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ovf_seen_q |-> overflow_o)
    else $error("overflow flag cleared after it was reported");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (max_degree_o >= last_peak_q))
    else $error("maximum degree decreased");

endmodule

bind neighbor_dedup_hash ndh_checker #(
  .NODE_BITS (NODE_BITS),
  .EDGE_BITS (EDGE_BITS)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .neighbor_out_o (neighbor_out_o),
  .edge_count_o   (edge_count_o),
  .max_degree_o   (max_degree_o),
  .overflow_o     (overflow_o)
);
